// File: src/vdd_pkg.sv
package vdd_pkg;

    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_HASHWS = 3'd1,
        PH_WORD   = 3'd2,
        PH_VERWS  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_ESWS   = 3'd5,
        PH_ES_S   = 3'd6,
        PH_TERM   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } src_item_t;

    typedef struct packed {
        logic has_version;
        logic is_es3;
    } result_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_S     = 8'h73;

    localparam logic [2:0] WORD_LEN = 3'd7;

    // Letters of "version", indexed by position.
    function automatic logic [7:0] word_char(input logic [2:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                3'd0:    c = 8'h76;
                3'd1:    c = 8'h65;
                3'd2:    c = 8'h72;
                3'd3:    c = 8'h73;
                3'd4:    c = 8'h69;
                3'd5:    c = 8'h6F;
                3'd6:    c = 8'h6E;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

// File: src/vdd_in_stage.sv
module vdd_in_stage
    import vdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  src_item_t in_item,
    input  logic      advance,
    output logic      item_valid,
    output src_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    src_item_t item_reg;

    assign in_ready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// File: src/vdd_parser.sv
module vdd_parser
    import vdd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  src_item_t item,
    output logic      emit,
    output result_t   result,
    output logic      idle
);

    phase_t     phase_reg, phase_next;
    logic [2:0] idx_reg, idx_next;
    logic       decided_reg, decided_next;

    phase_t     ph;
    logic [2:0] idx;
    logic       dec;
    logic [7:0] c;
    logic       fin;
    logic       hv;
    logic       es;

    assign idle = decided_reg;

    // A first-flagged item restarts the parse before its byte is looked at.
    always_comb
    begin
        c   = item.ch;
        ph  = item.first ? PH_LEAD : phase_reg;
        idx = item.first ? 3'd0 : idx_reg;
        dec = item.first ? 1'b0 : decided_reg;
    end

    always_comb
    begin
        phase_next = ph;
        idx_next   = idx;
        fin        = 1'b0;
        hv         = 1'b0;
        es         = 1'b0;
        if (!dec)
        begin
            case (ph)
                PH_LEAD:
                begin
                    if (is_blank(c) || c == CH_CR || c == CH_LF)
                    begin
                        phase_next = PH_LEAD;
                    end
                    else if (c == CH_HASH)
                    begin
                        phase_next = PH_HASHWS;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                PH_HASHWS:
                begin
                    if (is_blank(c))
                    begin
                        phase_next = PH_HASHWS;
                    end
                    else if (c == word_char(3'd0))
                    begin
                        idx_next   = 3'd1;
                        phase_next = PH_WORD;
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                PH_WORD:
                begin
                    if (idx < WORD_LEN && c == word_char(idx))
                    begin
                        idx_next = idx + 3'd1;
                        if (idx_next == WORD_LEN)
                        begin
                            phase_next = PH_VERWS;
                        end
                    end
                    else
                    begin
                        fin = 1'b1;
                    end
                end
                PH_VERWS:
                begin
                    if (is_digit(c))
                    begin
                        phase_next = PH_DIGITS;
                    end
                    else if (!is_blank(c))
                    begin
                        fin = 1'b1;
                        hv  = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (is_blank(c))
                    begin
                        phase_next = PH_ESWS;
                    end
                    else if (!is_digit(c))
                    begin
                        fin = 1'b1;
                        hv  = 1'b1;
                    end
                end
                PH_ESWS:
                begin
                    if (c == CH_E)
                    begin
                        phase_next = PH_ES_S;
                    end
                    else if (!is_blank(c))
                    begin
                        fin = 1'b1;
                        hv  = 1'b1;
                    end
                end
                PH_ES_S:
                begin
                    if (c == CH_S)
                    begin
                        phase_next = PH_TERM;
                    end
                    else
                    begin
                        fin = 1'b1;
                        hv  = 1'b1;
                    end
                end
                PH_TERM:
                begin
                    fin = 1'b1;
                    hv  = 1'b1;
                    es  = (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || is_blank(c);
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end
        decided_next = dec || fin;
    end

    assign emit               = step && fin;
    assign result.has_version = hv;
    assign result.is_es3      = es;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            idx_reg     <= 3'd0;
            decided_reg <= 1'b1;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            decided_reg <= decided_next;
        end
    end

endmodule

// File: src/vdd_out_stage.sv
module vdd_out_stage
    import vdd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t result,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The register can take a new result when empty or when it is drained this cycle.
    assign advance    = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && advance)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && advance)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: src/version_directive_detector.sv
// Version directive detector: takes one source byte per cycle and reports, at most once per
// source, whether the text opens with a version directive and whether that directive
// carries the "es" suffix. A byte flagged in s_tuser starts a new source; bytes before
// the first flagged byte, and bytes after the outcome is known, give no result. A byte is
// accepted every cycle while the result side keeps up; the byte that decides a result
// passes through the input register and then the result register, and the parser state
// is updated when that result is loaded into the result register.
module version_directive_detector
    import vdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] first
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] has_version, [1] is_es3, [7:2] zero
);

    src_item_t in_item;
    src_item_t item;
    logic      item_valid;
    logic      advance;
    logic      step;
    logic      emit;
    logic      parser_idle;
    result_t   result;
    result_t   out_result;

    assign in_item.ch    = s_tdata;
    assign in_item.first = s_tuser;
    assign step          = item_valid && advance;

    vdd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    vdd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .emit   (emit),
        .result (result),
        .idle   (parser_idle)
    );

    vdd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

    assign m_tdata = {6'd0, out_result.is_es3, out_result.has_version};

    // An ES3 result is only ever given together with a found directive.
    a_es3_needs_version : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_result.has_version || !out_result.is_es3))
        else $error("is_es3 set without has_version");

    // A result only comes from a source under parse or one just started.
    a_emit_needs_source : assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!parser_idle || item.first))
        else $error("result from an idle parser");

    // Once a result is emitted the parser stays idle until the next first byte.
    a_idle_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> parser_idle)
        else $error("parser not idle after a result");

endmodule

// File: tb/version_directive_checker.sv
module version_directive_checker
    import vdd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] first
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [0] has_version, [1] is_es3, [7:2] zero
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [55:0] KEYWORD = "version";

    phase_t     phase;
    logic [2:0] word_pos;
    logic       settled;
    result_t    verdicts_due[$];

    function automatic logic [7:0] keyword_letter(input int i);
        return KEYWORD[8*(6-i) +: 8];
    endfunction

    function automatic logic space_or_tab(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB;
    endfunction

    function automatic logic decimal(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Advances the directive parser by one byte; returns 1 when this byte settles
    // the outcome of the current source, with the verdict in r.
    function automatic bit scan_byte(input logic [7:0] c, input logic f, output result_t r);
        bit decides;
        decides = 1'b0;
        r = '0;
        if (f)
        begin
            phase = PH_LEAD;
            word_pos = 3'd0;
            settled = 1'b0;
        end
        if (settled)
            return 1'b0;
        case (phase)
            PH_LEAD:
                if (c == CH_HASH)
                    phase = PH_HASHWS;
                else if (!(space_or_tab(c) || c == CH_CR || c == CH_LF))
                    decides = 1'b1;
            PH_HASHWS:
                if (c == keyword_letter(0))
                begin
                    word_pos = 3'd1;
                    phase = PH_WORD;
                end
                else if (!space_or_tab(c))
                    decides = 1'b1;
            PH_WORD:
                if (word_pos < 3'd7 && c == keyword_letter(int'(word_pos)))
                begin
                    word_pos = word_pos + 3'd1;
                    if (word_pos == 3'd7)
                        phase = PH_VERWS;
                end
                else
                    decides = 1'b1;
            PH_VERWS:
            begin
                r.has_version = 1'b1;
                if (decimal(c))
                    phase = PH_DIGITS;
                else if (!space_or_tab(c))
                    decides = 1'b1;
            end
            PH_DIGITS:
            begin
                r.has_version = 1'b1;
                if (space_or_tab(c))
                    phase = PH_ESWS;
                else if (!decimal(c))
                    decides = 1'b1;
            end
            PH_ESWS:
            begin
                r.has_version = 1'b1;
                if (c == CH_E)
                    phase = PH_ES_S;
                else if (!space_or_tab(c))
                    decides = 1'b1;
            end
            PH_ES_S:
            begin
                r.has_version = 1'b1;
                if (c == CH_S)
                    phase = PH_TERM;
                else
                    decides = 1'b1;
            end
            PH_TERM:
            begin
                r.has_version = 1'b1;
                r.is_es3 = c == CH_NUL || c == CH_CR || c == CH_LF || space_or_tab(c);
                decides = 1'b1;
            end
            default:
                decides = 1'b1;
        endcase
        if (decides)
            settled = 1'b1;
        else
            r = '0;
        return decides;
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            phase = PH_LEAD;
            word_pos = 3'd0;
            settled = 1'b1;
            errors = 0;
            pending = 0;
            verdicts_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.has_version = m_tdata[0];
                got.is_es3 = m_tdata[1];
                if (verdicts_due.size() == 0)
                    note_failure($sformatf("unexpected result has_version=%0b is_es3=%0b",
                                           got.has_version, got.is_es3));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (got != want)
                        note_failure($sformatf(
                            "expected has_version=%0b is_es3=%0b, got has_version=%0b is_es3=%0b",
                            want.has_version, want.is_es3, got.has_version, got.is_es3));
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (scan_byte(s_tdata, s_tuser, want))
                    verdicts_due.push_back(want);
            end
            pending = verdicts_due.size();
        end
    end

endmodule

// File: tb/tb_version_directive_detector.sv
module tb_version_directive_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import vdd_pkg::*;

    localparam logic [31:0] LEAD_CHARS = {CH_LF, CH_CR, CH_TAB, CH_SPACE};
    localparam logic [39:0] TERM_CHARS = {CH_TAB, CH_SPACE, CH_LF, CH_CR, CH_NUL};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] ch
    logic       s_tuser = 1'b0;    // [0] first
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] has_version, [1] is_es3, [7:2] zero
    int         errors;
    int         pending;
    int         idle_pct = 0;
    int         stall_pct = 0;
    int         bytes_sent = 0;

    version_directive_detector uut (.*);

    version_directive_checker chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        m_tready <= $urandom_range(99) >= stall_pct;

    task automatic push_byte(input logic [7:0] c, input logic f);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tuser <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_source(input logic [7:0] text[$]);
        foreach (text[i])
            push_byte(text[i], i == 0);
    endtask

    // Sends a string as a new source, optionally closed by a NUL byte.
    task automatic push_text(input string s, input bit nul);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        if (nul)
            text.push_back(CH_NUL);
        send_source(text);
    endtask

    function automatic logic [7:0] pick_blank();
        return ($urandom_range(1) != 0) ? CH_SPACE : CH_TAB;
    endfunction

    // Mostly a well-formed directive with random spacing, digits and terminator,
    // sometimes damaged or cut short; otherwise plain noise.
    task automatic send_random_source();
        logic [7:0] text[$];
        string      word;
        int         keep;
        word = "version";
        if ($urandom_range(99) < 20)
        begin
            repeat ($urandom_range(1, 6))
                text.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 3))
                text.push_back(LEAD_CHARS[8*$urandom_range(3) +: 8]);
            text.push_back(CH_HASH);
            repeat ($urandom_range(0, 2))
                text.push_back(pick_blank());
            for (int i = 0; i < word.len(); i++)
                text.push_back(word[i]);
            repeat ($urandom_range(0, 2))
                text.push_back(pick_blank());
            repeat ($urandom_range(0, 3))
                text.push_back(8'(CH_ZERO + $urandom_range(9)));
            repeat ($urandom_range(0, 2))
                text.push_back(pick_blank());
            text.push_back(CH_E);
            text.push_back(CH_S);
            if ($urandom_range(99) < 80)
                text.push_back(TERM_CHARS[8*$urandom_range(4) +: 8]);
            else
                text.push_back(8'($urandom_range(255)));
            if ($urandom_range(99) < 25)
                text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(99) < 10)
                text[$urandom_range(text.size() - 1)] = CH_NUL;
            // A source cut short leaves the parser mid-directive for the next first byte.
            if ($urandom_range(99) < 10)
            begin
                keep = $urandom_range(1, text.size());
                while (text.size() > keep)
                    void'(text.pop_back());
            end
        end
        repeat ($urandom_range(0, 2))
            text.push_back(8'($urandom_range(255)));
        send_source(text);
    endtask

    initial
    begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any source has started are ignored.
        push_byte("a", 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_text("#version 300 es", 1'b1);
        push_text(" \t\r\n#  version\t100 \tes\n", 1'b0);
        push_text("#version 3 es\r", 1'b0);
        push_text(" #version 310 es\t", 1'b0);
        push_text("#version 09 es ", 1'b0);
        push_text("#version 300 esx", 1'b0);
        push_text("#version es", 1'b1);
        push_text("#version300es", 1'b1);
        push_text("#version", 1'b1);
        push_text("#version 300", 1'b1);
        push_text("#version 300 ", 1'b1);
        push_text("#version 300 e", 1'b1);
        push_text("#versio", 1'b1);
        push_text("#", 1'b1);
        push_text("", 1'b1);
        push_text("#version /", 1'b0);
        push_text("#version 3: es", 1'b1);
        push_text("#vErsion 1 es", 1'b1);
        push_text("x", 1'b0);
        push_byte(8'hFF, 1'b1);
        // Restart in the middle of a directive, then trailing bytes after the outcome.
        push_text("#vers", 1'b0);
        push_text("#version 1 es", 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 75; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            target = bytes_sent + 100;
            while (bytes_sent < target)
                send_random_source();
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
